@@ rtl/timestamp_order_sorter_core_defines.svh @@
// Assertion macros shared by the sorter modules
`ifndef TIMESTAMP_ORDER_SORTER_CORE_DEFINES_SVH
`define TIMESTAMP_ORDER_SORTER_CORE_DEFINES_SVH

// Implication checked on every edge outside reset
`define TOS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on every edge outside reset
`define TOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/tos_pkg.sv @@
`timescale 1ns / 1ps
package tos_pkg;

    localparam int KEY_W = 40;
    localparam int ID_W  = 7;
    localparam int ENT_W = KEY_W + ID_W;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        batch_end;
    } tos_in_t;

    typedef struct packed {
        logic [6:0] identifier;
        logic       run_end;
        logic       overflowed;
    } tos_out_t;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_SETTLE,
        ST_DRAIN
    } tos_state_t;

    // controller to datapath
    typedef struct packed {
        logic insert;
        logic pop;
        logic clear;
    } tos_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;
    } tos_stat_t;

endpackage

@@ rtl/tos_datapath.sv @@
`timescale 1ns / 1ps
`include "timestamp_order_sorter_core_defines.svh"
module tos_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tos_pkg::tos_cmd_t   cmd,
    input  tos_pkg::tos_in_t    in_item,
    output tos_pkg::tos_stat_t  stat,
    output logic [6:0]          head_id
);
    import tos_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Systolic insertion chain: cell 0 holds the smallest entry.
    logic [ENT_W-1:0] cell_reg  [CAPACITY];
    logic [ENT_W-1:0] cell_next [CAPACITY];
    logic [CAPACITY-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ENT_W-1:0] new_ent;
    logic [CAPACITY-1:0] gt;

    assign new_ent = {in_item.year, in_item.month, in_item.day, in_item.hour,
                      in_item.minute, in_item.second, 7'(cnt_reg + 1'b1)};

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            gt[i] = occ_reg[i] && (cell_reg[i] > new_ent);
        occ_next = occ_reg;
        cnt_next = cnt_reg;
        for (int i = 0; i < CAPACITY; i++)
            cell_next[i] = cell_reg[i];
        if (cmd.clear)
        begin
            occ_next = '0;
            cnt_next = '0;
        end
        else if (cmd.insert)
        begin
            // entries greater than the new one shift up; new one lands at first free/greater
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (gt[i])
                    cell_next[i] = (i == 0) ? new_ent :
                                   (gt[(i == 0) ? 0 : i - 1] ? cell_reg[(i == 0) ? 0 : i - 1]
                                                               : new_ent);
                else if (!occ_reg[i] && (i == 0 || (occ_reg[(i == 0) ? 0 : i - 1])))
                    cell_next[i] = (i == 0 || !gt[(i == 0) ? 0 : i - 1]) ? new_ent
                                   : cell_reg[(i == 0) ? 0 : i - 1];
            end
            occ_next = {occ_reg[CAPACITY-2:0], 1'b1};
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
                cell_next[i] = cell_reg[i+1];
            occ_next = {1'b0, occ_reg[CAPACITY-1:1]};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
            cell_reg[i] <= cell_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            cnt_reg <= cnt_next;
        end
    end

    assign stat.full     = occ_reg[CAPACITY-1];
    assign stat.empty    = !occ_reg[0];
    assign stat.one_left = occ_reg[0] && ((CAPACITY < 2) || !occ_reg[1]);
    assign head_id       = cell_reg[0][ID_W-1:0];

    `TOS_ASSERT_IMPL(a_occ_matches_cnt, clk, rst_n, 1'b1, $countones(occ_reg) == cnt_reg)
    `TOS_ASSERT_IMPL(a_no_insert_full, clk, rst_n, cmd.insert, !stat.full)
    `TOS_ASSERT_NEXT(a_pop_shrinks, clk, rst_n, cmd.pop && !cmd.clear,
                     cnt_reg == $past(cnt_reg) - 1'b1)

endmodule

@@ rtl/tos_ctrl.sv @@
`timescale 1ns / 1ps
`include "timestamp_order_sorter_core_defines.svh"
module tos_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               batch_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               run_end,
    output logic               overflowed,
    input  tos_pkg::tos_stat_t stat,
    output tos_pkg::tos_cmd_t  cmd
);
    import tos_pkg::*;

    tos_state_t state_reg, state_next;
    logic ovf_reg, ovf_next;
    logic take;

    assign take = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        ovf_next   = ovf_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_FILL:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (stat.full)
                        ovf_next = 1'b1;
                    else
                        cmd.insert = 1'b1;
                    if (batch_end)
                        state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                // store is never empty here: the batch_end item was inserted unless the store was full
                state_next = stat.empty ? ST_FILL : ST_DRAIN;
                if (stat.empty)
                    ovf_next = 1'b0;
            end
            ST_DRAIN:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.pop = 1'b1;
                    if (stat.one_left)
                    begin
                        state_next = ST_FILL;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    assign run_end    = stat.one_left;
    assign overflowed = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
        end
    end

    `TOS_ASSERT_IMPL(a_out_nonempty, clk, rst_n, out_valid, !stat.empty)
    `TOS_ASSERT_IMPL(a_no_overlap, clk, rst_n, in_ready, !out_valid)
    `TOS_ASSERT_NEXT(a_last_returns, clk, rst_n, take && run_end, state_reg == ST_FILL)

endmodule

@@ rtl/timestamp_order_sorter_core.sv @@
`timescale 1ns / 1ps
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | in_data  (tos_in_t)
// out     | out_valid / out_ready  | out_data (tos_out_t)
// One timestamp item is accepted per cycle; each is inserted into its sorted place
// in a systolic register chain in that cycle, unless full. After the batch_end item,
// a settle state, then one result per cycle while out_ready is high (one per stored
// entry). Input is held off during the drain. Reset empties the chain at once.
module timestamp_order_sorter_core #(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tos_pkg::tos_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tos_pkg::tos_out_t out_data
);
    import tos_pkg::*;

    tos_cmd_t  cmd;
    tos_stat_t stat;
    logic [6:0] head_id;
    logic run_end, overflowed;

    tos_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .batch_end  (in_data.batch_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .run_end    (run_end),
        .overflowed (overflowed),
        .stat       (stat),
        .cmd        (cmd)
    );

    tos_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_item (in_data),
        .stat    (stat),
        .head_id (head_id)
    );

    assign out_data.identifier = head_id;
    assign out_data.run_end    = run_end;
    assign out_data.overflowed = overflowed;

endmodule
